// File: rtl/nsic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsic_pkg
// Shared widths, limits and result type of the non-strict inversion counter.
// ----------------------------------------------------------------------------
package nsic_pkg;

    localparam int VALUE_W = 10;
    localparam int TOTAL_W = 23;
    localparam int COUNT_W = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [TOTAL_W-1:0] pair_total;
        logic               done_res;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/nsic_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsic_in_if
// Input channel: one sequence element per word, with end-of-sequence flag.
// ----------------------------------------------------------------------------
interface nsic_in_if
    import nsic_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/nsic_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsic_out_if
// Output channel: running pair total per word, with end-of-sequence flag.
// ----------------------------------------------------------------------------
interface nsic_out_if
    import nsic_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] pair_total;
    logic               done_res;

    modport source (output valid, output pair_total, output done_res, input ready);
    modport sink   (input valid, input pair_total, input done_res, output ready);
endinterface
`default_nettype wire

// File: rtl/non_strict_inversion_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// non_strict_inversion_counter_top
// Counts pairs (earlier, later) with earlier value >= later value per sequence.
// ----------------------------------------------------------------------------
// Each input word carries one sequence element; each produces exactly one
// output word with the running pair total, and the word whose last flag is
// set returns the final answer with done_res high. Values at or above
// VALUE_RANGE count as VALUE_RANGE-1. Two RAMs with registered read data hold
// the state: a Fenwick tree over reversed values (so "stored values not below
// v" is a prefix sum) and a plain per-value count used for saturation.
// Each element makes p = popcount(VALUE_RANGE - v) tree reads in the prefix
// query, then a serial read-modify-write walk through the tree RAM over the u
// nodes of the update path (u at most log2(VALUE_RANGE) + 1). An element that
// is not stored skips the update. With the default VALUE_RANGE, p + u never
// exceeds 12. A new word is accepted only after the previous result has gone
// to the output register. After reset and after every word with last set, the
// block sweeps both RAMs to zero with input ready held low. Elements past
// MAX_ITEMS in one sequence still add to the total but are not stored. The
// output register lets the next input word be accepted while a result still
// waits downstream.
// ----------------------------------------------------------------------------
module non_strict_inversion_counter_top
    import nsic_pkg::*;
#(
    parameter int VALUE_RANGE = 1024,
    parameter int MAX_ITEMS   = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nsic_in_if.sink   i_in,
    nsic_out_if.source o_out
);
    localparam int AW = $clog2(VALUE_RANGE);
    localparam int TW = $clog2(MAX_ITEMS + 1);

    logic               res_valid;
    logic               res_ready;
    t_result            res;

    logic               tree_we;
    logic [AW-1:0]      tree_waddr;
    logic [TW-1:0]      tree_wdata;
    logic               tree_re;
    logic [AW-1:0]      tree_raddr;
    logic [TW-1:0]      tree_rdata;

    logic               cnt_we;
    logic [AW-1:0]      cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               cnt_re;
    logic [AW-1:0]      cnt_raddr;
    logic [COUNT_W-1:0] cnt_rdata;

    logic               r_out_valid;
    t_result            r_out;

    nsic_engine #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_tree_we    (tree_we),
        .o_tree_waddr (tree_waddr),
        .o_tree_wdata (tree_wdata),
        .o_tree_re    (tree_re),
        .o_tree_raddr (tree_raddr),
        .i_tree_rdata (tree_rdata),
        .o_cnt_we     (cnt_we),
        .o_cnt_waddr  (cnt_waddr),
        .o_cnt_wdata  (cnt_wdata),
        .o_cnt_re     (cnt_re),
        .o_cnt_raddr  (cnt_raddr),
        .i_cnt_rdata  (cnt_rdata)
    );

    // Fenwick tree nodes, one per value bucket
    nsic_ram #(
        .DEPTH (VALUE_RANGE),
        .WIDTH (TW)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_waddr),
        .i_wdata (tree_wdata),
        .i_re    (tree_re),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rdata)
    );

    // saturating per-value counts
    nsic_ram #(
        .DEPTH (VALUE_RANGE),
        .WIDTH (COUNT_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // output word register: take a new result when empty or being drained
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pair_total = r_out.pair_total;
    assign o_out.done_res   = r_out.done_res;
endmodule
`default_nettype wire

// File: rtl/nsic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsic_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module nsic_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/nsic_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsic_engine
// Sequencer: Fenwick prefix query, Fenwick update and per-value count update
// over the two stores, running total, and clearing sweep.
// ----------------------------------------------------------------------------
module nsic_engine
    import nsic_pkg::*;
#(
    parameter int VALUE_RANGE = 1024,
    parameter int MAX_ITEMS   = 4096,
    localparam int AW = $clog2(VALUE_RANGE),
    localparam int TW = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    nsic_in_if.sink            i_in,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output t_result            o_res,
    // Fenwick tree store
    output logic               o_tree_we,
    output logic [AW-1:0]      o_tree_waddr,
    output logic [TW-1:0]      o_tree_wdata,
    output logic               o_tree_re,
    output logic [AW-1:0]      o_tree_raddr,
    input  wire logic [TW-1:0] i_tree_rdata,
    // per-value count store
    output logic               o_cnt_we,
    output logic [AW-1:0]      o_cnt_waddr,
    output logic [COUNT_W-1:0] o_cnt_wdata,
    output logic               o_cnt_re,
    output logic [AW-1:0]      o_cnt_raddr,
    input  wire logic [COUNT_W-1:0] i_cnt_rdata
);
    localparam int IW = $clog2(VALUE_RANGE + 1);
    localparam int UW = IW + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_UPD,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_v;
    logic               r_last;
    logic [IW-1:0]      r_qi;
    logic [UW-1:0]      r_ui;
    logic [TW-1:0]      r_sum;
    logic               r_pend;
    logic               r_upd_pend;
    logic [AW-1:0]      r_upd_addr;
    logic [TOTAL_W-1:0] r_total;
    logic [TW-1:0]      r_seen;

    logic               accept;
    logic [AW-1:0]      v_in;
    logic [IW-1:0]      start_i;
    logic [IW-1:0]      q_low;
    logic [UW-1:0]      u_low;
    logic               q_issue;
    logic               q_finish;
    logic               u_issue;
    logic [TOTAL_W:0]   sum_ext;
    logic [TOTAL_W-1:0] total_sat;
    logic               seen_room;
    logic               do_inc;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // clamp out-of-range values to the top bucket
    always_comb begin
        if (32'(i_in.value) >= VALUE_RANGE) begin
            v_in = AW'(VALUE_RANGE - 1);
        end else begin
            v_in = AW'(i_in.value);
        end
    end

    // tree is indexed by reversed value so "not below v" is a prefix
    assign start_i  = IW'(VALUE_RANGE) - IW'(v_in);
    assign q_low    = r_qi & (~r_qi + IW'(1));
    assign u_low    = r_ui & (~r_ui + UW'(1));
    assign q_issue  = (r_state == S_QUERY) && (r_qi != '0);
    assign q_finish = (r_state == S_QUERY) && (r_qi == '0) && !r_pend;
    assign u_issue  = (r_state == S_UPD) && (r_ui <= UW'(VALUE_RANGE));

    assign sum_ext   = {1'b0, r_total} + (TOTAL_W + 1)'(r_sum);
    assign total_sat = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    assign seen_room = (r_seen < TW'(MAX_ITEMS));
    assign do_inc    = seen_room && (i_cnt_rdata < COUNT_MAX);

    always_comb begin
        o_tree_we    = 1'b0;
        o_tree_waddr = r_upd_addr;
        o_tree_wdata = i_tree_rdata + TW'(1);
        o_tree_re    = 1'b0;
        o_tree_raddr = AW'(r_qi - IW'(1));
        o_cnt_we     = 1'b0;
        o_cnt_waddr  = r_v;
        o_cnt_wdata  = i_cnt_rdata + COUNT_W'(1);
        o_cnt_re     = accept;
        o_cnt_raddr  = v_in;
        unique case (r_state)
            S_CLEAR: begin
                o_tree_we    = 1'b1;
                o_tree_waddr = r_clr_addr;
                o_tree_wdata = '0;
                o_cnt_we     = 1'b1;
                o_cnt_waddr  = r_clr_addr;
                o_cnt_wdata  = '0;
            end
            S_QUERY: begin
                o_tree_re = q_issue;
                o_cnt_we  = q_finish && do_inc;
            end
            S_UPD: begin
                o_tree_we    = r_upd_pend;
                o_tree_re    = u_issue;
                o_tree_raddr = AW'(r_ui - UW'(1));
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.pair_total = r_total;
    assign o_res.done_res   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_seen     <= '0;
            r_pend     <= 1'b0;
            r_upd_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(VALUE_RANGE - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_v     <= v_in;
                        r_last  <= i_in.last;
                        r_qi    <= start_i;
                        r_ui    <= UW'(start_i);
                        r_sum   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_QUERY;
                    end
                end
                S_QUERY: begin
                    // accumulate the node read in the previous cycle
                    if (r_pend) begin
                        r_sum <= r_sum + i_tree_rdata;
                    end
                    r_pend <= q_issue;
                    if (q_issue) begin
                        r_qi <= r_qi - q_low;
                    end
                    if (q_finish) begin
                        r_total <= total_sat;
                        if (seen_room) begin
                            r_seen <= r_seen + TW'(1);
                        end
                        r_upd_pend <= 1'b0;
                        r_state    <= do_inc ? S_UPD : S_DONE;
                    end
                end
                S_UPD: begin
                    // read-modify-write chain; addresses strictly rise
                    r_upd_pend <= u_issue;
                    if (u_issue) begin
                        r_upd_addr <= AW'(r_ui - UW'(1));
                        r_ui       <= r_ui + u_low;
                    end else if (!r_upd_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        if (r_last) begin
                            r_total    <= '0;
                            r_seen     <= '0;
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/nsic_pair_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nsic_pair_checker
// Watches both channels of the inversion counter, predicts each pair total
// from its own per-value count store and compares every output word in order.
// ----------------------------------------------------------------------------
module nsic_pair_checker
    import nsic_pkg::*;
#(
    parameter int VALUE_RANGE = 1024,
    parameter int MAX_ITEMS   = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nsic_in_if   i_in,
    nsic_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    logic [COUNT_W-1:0] seen_per_value [VALUE_RANGE];
    logic [TOTAL_W-1:0] pairs_so_far;
    int unsigned        stored_items;
    t_result            expected_totals [$];
    int                 mismatch_cnt;
    int                 words_checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatch_cnt = 0;
        words_checked = 0;
    end

    function automatic void clear_store();
        int u;
        for (u = 0; u < VALUE_RANGE; u++) begin
            seen_per_value[u] = '0;
        end
        pairs_so_far = '0;
        stored_items = 0;
    endfunction

    // Add stored values not below the new one, then store it (up to the cap).
    function automatic t_result count_pairs(input logic [VALUE_W-1:0] value,
                                            input logic last);
        int unsigned     v;
        int              u;
        longint unsigned sum;
        t_result         res;
        v = (value >= VALUE_RANGE) ? VALUE_RANGE - 1 : value;
        sum = pairs_so_far;
        for (u = v; u < VALUE_RANGE; u++) begin
            sum += seen_per_value[u];
        end
        if (sum > TOTAL_MAX) begin
            sum = TOTAL_MAX;
        end
        pairs_so_far = sum[TOTAL_W-1:0];
        if (stored_items < MAX_ITEMS) begin
            if (seen_per_value[v] != COUNT_MAX) begin
                seen_per_value[v] = seen_per_value[v] + 1'b1;
            end
            stored_items++;
        end
        res.pair_total = pairs_so_far;
        res.done_res   = last;
        if (last) begin
            clear_store();
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_store();
            expected_totals.delete();
        end else begin
            // check the outgoing word first: it can never belong to this edge's input
            if (i_out.valid && i_out.ready) begin
                if (expected_totals.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: unexpected word pair_total=%0d done_res=%0b",
                                 $realtime, i_out.pair_total, i_out.done_res);
                    end
                end else begin
                    want = expected_totals.pop_front();
                    if (want.pair_total !== i_out.pair_total ||
                        want.done_res !== i_out.done_res) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: word %0d expected pair_total=%0d done_res=%0b, got pair_total=%0d done_res=%0b",
                                     $realtime, words_checked, want.pair_total,
                                     want.done_res, i_out.pair_total, i_out.done_res);
                        end
                    end
                end
                words_checked++;
            end
            if (i_in.valid && i_in.ready) begin
                expected_totals = {expected_totals, count_pairs(i_in.value, i_in.last)};
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= expected_totals.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sequences into the non-strict inversion counter and judges the run.
// ----------------------------------------------------------------------------
// A short directed set covers value extremes, equal values, single-element
// sequences and alternating bit patterns. Random sequences of mixed length
// and value spread follow. Both sides idle at random per word; the checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import nsic_pkg::*;

    localparam int VALUE_RANGE  = 1024;
    localparam int MAX_ITEMS    = 4096;
    localparam int RANDOM_WORDS = 750;
    localparam int MAX_IDLE     = 18;
    localparam int TAIL_CYCLES  = 64;
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;

    // value spread of one random sequence
    typedef enum logic [1:0] {
        SPREAD_FULL,
        SPREAD_CLUSTER,
        SPREAD_EDGES
    } t_spread;

    logic clk;
    logic rst_n;
    bit   tx_idle_on;
    bit   rx_idle_on;
    int   fail_count;
    int   pending_words;

    nsic_in_if  in_ch ();
    nsic_out_if out_ch ();

    non_strict_inversion_counter_top #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    nsic_pair_checker #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) pair_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one word: idle for a drawn gap, then hold it until accepted.
    // Valid stays high afterwards so back-to-back words need no extra edge.
    task automatic send_word(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.last  <= last;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    // Receiver: stall for a drawn number of cycles, then take one word.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin
        int                 random_words;
        int                 seq_len;
        int                 k;
        t_spread            spread;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] v;

        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        rst_n       <= 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-word sequences at both value extremes.
        send_word(10'd0, 1'b1);
        send_word(10'd1023, 1'b1);
        // extremes interleaved, then an equal pair
        send_word(10'd1023, 1'b0);
        send_word(10'd0, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd0, 1'b0);
        send_word(10'd512, 1'b0);
        send_word(10'd512, 1'b1);
        // strictly ascending: no pairs at all
        send_word(10'd1, 1'b0);
        send_word(10'd2, 1'b0);
        send_word(10'd3, 1'b0);
        send_word(10'd4, 1'b1);
        // strictly descending: every pair counts
        send_word(10'd1000, 1'b0);
        send_word(10'd700, 1'b0);
        send_word(10'd300, 1'b0);
        send_word(10'd0, 1'b1);
        // alternating bit patterns
        send_word(10'h155, 1'b0);
        send_word(10'h2AA, 1'b0);
        send_word(10'h155, 1'b0);
        send_word(10'h2AA, 1'b1);
        // all equal: ties count as pairs
        send_word(10'd7, 1'b0);
        send_word(10'd7, 1'b0);
        send_word(10'd7, 1'b0);
        send_word(10'd7, 1'b1);

        // Pause the sender until the block has returned everything.
        wait_drained();

        // Random sequences: mostly short, some long, with varied value spread.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
                                                  : $urandom_range(1, 24);
            spread = t_spread'($urandom_range(0, 2));
            base   = VALUE_W'($urandom_range(0, 1023));
            // leave some sequences free of idling on either side
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            for (k = 0; k < seq_len; k++) begin
                unique case (spread)
                    SPREAD_CLUSTER: begin
                        v = base + VALUE_W'($urandom_range(0, 3));
                    end
                    SPREAD_EDGES: begin
                        v = $urandom_range(0, 1) ? VALUE_W'(1023 - $urandom_range(0, 1))
                                                 : VALUE_W'($urandom_range(0, 1));
                    end
                    default: begin
                        v = VALUE_W'($urandom_range(0, 1023));
                    end
                endcase
                send_word(v, k == seq_len - 1);
                random_words++;
            end
        end

        // Let the last words drain, then give the block time to show any
        // stray output before the verdict.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
